[sv/wbf_pkg.sv]
// ----------------------------------------------------------------------------
// wbf_pkg: shared types and constants of the window brightness force block
// Holds the neighbor weight table, the tap word that travels from the
// sequencer to the multiply-accumulate unit, and the register and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wbf_pkg;

  // Offsets run from -8 to 7 at most, so four signed bits always hold them.
  localparam int OFF_W = 4;

  // Weight components are Q.14 and reach +/-16384.
  localparam int WGT_W = 16;

  // Brightness term b = 65536 - p*inverse_divisor, signed.
  localparam int B_W = 25;

  // Product of one weight and one brightness term.
  localparam int PROD_W = 41;

  // Output field widths.
  localparam int FORCE_W = 24;
  localparam int CNT_OUT_W = 7;

  // Request kinds carried in the input tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_INVERSE_DIVISOR = 2'd2;

  // Magnitude of round(a*16384/(a*a+b*b)), ties away from zero,
  // first index a, second index b, both from 0 to 8.
  localparam logic [14:0] WMAG [0:8][0:8] = '{
    '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
    '{15'd16384, 15'd8192, 15'd3277, 15'd1638, 15'd964, 15'd630, 15'd443,
      15'd328, 15'd252},
    '{15'd8192, 15'd6554, 15'd4096, 15'd2521, 15'd1638, 15'd1130, 15'd819,
      15'd618, 15'd482},
    '{15'd5461, 15'd4915, 15'd3781, 15'd2731, 15'd1966, 15'd1446, 15'd1092,
      15'd847, 15'd673},
    '{15'd4096, 15'd3855, 15'd3277, 15'd2621, 15'd2048, 15'd1598, 15'd1260,
      15'd1008, 15'd819},
    '{15'd3277, 15'd3151, 15'd2825, 15'd2409, 15'd1998, 15'd1638, 15'd1343,
      15'd1107, 15'd920},
    '{15'd2731, 15'd2657, 15'd2458, 15'd2185, 15'd1890, 15'd1612, 15'd1365,
      15'd1157, 15'd983},
    '{15'd2341, 15'd2294, 15'd2164, 15'd1977, 15'd1764, 15'd1550, 15'd1349,
      15'd1170, 15'd1015},
    '{15'd2048, 15'd2016, 15'd1928, 15'd1796, 15'd1638, 15'd1473, 15'd1311,
      15'd1160, 15'd1024}
  };

  // One neighbor handed to the multiply-accumulate unit.
  typedef struct packed {
    logic hit;
    logic signed [WGT_W-1:0] wx;
    logic signed [WGT_W-1:0] wy;
  } wbf_tap_t;

  // Signed weight component along num_off for the offset pair.
  function automatic logic signed [WGT_W-1:0] weight_of(
    input logic signed [OFF_W-1:0] num_off,
    input logic signed [OFF_W-1:0] oth_off
  );
    logic [OFF_W-1:0] a_mag;
    logic [OFF_W-1:0] b_mag;
    logic [14:0] mag;
    a_mag = num_off[OFF_W-1] ? OFF_W'(-num_off) : OFF_W'(num_off);
    b_mag = oth_off[OFF_W-1] ? OFF_W'(-oth_off) : OFF_W'(oth_off);
    mag = WMAG[a_mag][b_mag];
    return num_off[OFF_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

[sv/wbf_pixel_ram.sv]
// ----------------------------------------------------------------------------
// wbf_pixel_ram: pixel store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_pixel_ram #(
  parameter int DEPTH = 262144,
  parameter int ADDR_W = 18
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[sv/wbf_mac.sv]
// ----------------------------------------------------------------------------
// wbf_mac: neighbor multiply-accumulate pipeline
// Turns each read pixel into its brightness term, weights it along x and y
// and adds both products into wide accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_mac #(
  parameter int ACC_W = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear,
  input  wire logic [15:0]             inverse_divisor,
  input  wire wbf_pkg::wbf_tap_t       tap_in,
  input  wire logic [7:0]              pixel,
  output logic                         busy,
  output logic signed [ACC_W-1:0]      sum_x,
  output logic signed [ACC_W-1:0]      sum_y
);

  import wbf_pkg::*;

  wbf_tap_t tap1;
  wbf_tap_t tap2;
  logic signed [B_W-1:0] bright;
  logic hit3;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic [23:0] scaled;

  assign scaled = 24'(pixel) * 24'(inverse_divisor);

  // Stage 1 lines the tap up with the pixel coming out of the store.
  // Stage 2 forms the brightness term, stage 3 the two products.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap1.hit <= 1'b0;
      tap2.hit <= 1'b0;
      hit3 <= 1'b0;
    end else begin
      tap1.hit <= tap_in.hit;
      tap2.hit <= tap1.hit;
      hit3 <= tap2.hit;
    end
    tap1.wx <= tap_in.wx;
    tap1.wy <= tap_in.wy;
    tap2.wx <= tap1.wx;
    tap2.wy <= tap1.wy;
    bright <= B_W'(65536) - $signed({1'b0, scaled});
    prod_x <= PROD_W'(tap2.wx) * PROD_W'(bright);
    prod_y <= PROD_W'(tap2.wy) * PROD_W'(bright);
  end

  // Accumulators, cleared when a query starts.
  always_ff @(posedge clk) begin
    if (clear) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (hit3) begin
      sum_x <= sum_x + ACC_W'(prod_x);
      sum_y <= sum_y + ACC_W'(prod_y);
    end
  end

  assign busy = tap1.hit | tap2.hit | hit3;

endmodule

`default_nettype wire

[sv/wbf_divider.sv]
// ----------------------------------------------------------------------------
// wbf_divider: restoring divider, two lanes over one divisor
// Produces one quotient bit per lane and cycle; both lanes share the count.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_divider #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num_a,
  input  wire logic [NUM_W-1:0] num_b,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo_a,
  output logic      [NUM_W-1:0] quo_b
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_a;
  logic [DEN_W-1:0] rem_b;
  logic [DEN_W:0] trial_a;
  logic [DEN_W:0] trial_b;
  logic ge_a;
  logic ge_b;
  logic [DEN_W-1:0] rem_a_next;
  logic [DEN_W-1:0] rem_b_next;

  // One trial subtraction per lane.
  always_comb begin
    trial_a = {rem_a, quo_a[NUM_W-1]};
    trial_b = {rem_b, quo_b[NUM_W-1]};
    ge_a = trial_a >= {1'b0, den_q};
    ge_b = trial_b >= {1'b0, den_q};
    rem_a_next = ge_a ? DEN_W'(trial_a - {1'b0, den_q}) : trial_a[DEN_W-1:0];
    rem_b_next = ge_b ? DEN_W'(trial_b - {1'b0, den_q}) : trial_b[DEN_W-1:0];
  end

  // The quotient registers start with the dividends and shift bits in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      quo_a <= num_a;
      quo_b <= num_b;
      rem_a <= '0;
      rem_b <= '0;
      den_q <= den;
    end else if (busy) begin
      quo_a <= {quo_a[NUM_W-2:0], ge_a};
      quo_b <= {quo_b[NUM_W-2:0], ge_b};
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

endmodule

`default_nettype wire

[sv/window_brightness_force_top.sv]
// ----------------------------------------------------------------------------
// window_brightness_force_top: neighborhood brightness force
// Stores a grayscale image loaded by write words and answers force queries
// by scanning the window around a position through one multiply-accumulate
// pipeline, then dividing both sums by the neighbor count.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata / data                          tuser
//  s_axis    in         pos_x, pos_y, pixel_value (32 bits)   req_type
//  m_axis    out        force_x, force_y, valid_count (56)    -
//  cfg       in         cfg_index selects, cfg_data written   -
//
// A write word moves the sequencer to the finish state, which loads the output
// register; the next word can be taken once the sequencer is back in idle.
// A query reads the store once per window position, waits in the drain state
// until the pipeline is empty, takes a setup state, runs the shared divider
// and then loads the output register in the finish state.
// A query with no neighbor inside the image skips the divider.
// Reset is synchronous; the pixel store is not cleared.
// A finished word waits in the output register while the next word is taken;
// the next result then waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module window_brightness_force_top #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int WINDOW = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [9:0] pos_x, [19:10] pos_y, [27:20] pixel_value, [31:28] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] req_type
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] force_x, [47:24] force_y, [54:48] valid_count, [55] zero
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import wbf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(WINDOW * WINDOW);
  localparam int ACC_W = PROD_W + CNT_W;
  localparam int QW = ACC_W - 16;
  localparam logic signed [OFF_W-1:0] OFF_LO = OFF_W'(-(WINDOW / 2));
  localparam logic signed [OFF_W-1:0] OFF_HI = OFF_W'(WINDOW - WINDOW / 2 - 1);
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  logic [9:0] image_width;
  logic [9:0] image_height;
  logic [15:0] inverse_divisor;

  logic [9:0] in_pos_x;
  logic [9:0] in_pos_y;
  logic [7:0] in_pixel;
  logic accept;

  logic [9:0] qx;
  logic [9:0] qy;
  logic signed [OFF_W-1:0] oi;
  logic signed [OFF_W-1:0] oj;
  logic [CNT_W-1:0] cnt;
  logic zero_res;
  logic neg_x;
  logic neg_y;

  logic signed [11:0] nx;
  logic signed [11:0] ny;
  logic [12:0] width_eff;
  logic [12:0] height_eff;
  logic inb;
  logic center;
  wbf_tap_t tap;

  logic ram_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0] rd_data;

  logic mac_busy;
  logic mac_clear;
  logic signed [ACC_W-1:0] sum_x;
  logic signed [ACC_W-1:0] sum_y;

  logic [ACC_W-1:0] rnd;
  logic [ACC_W-1:0] mag_x;
  logic [ACC_W-1:0] mag_y;
  logic div_start;
  logic div_done;
  logic [QW-1:0] quo_x;
  logic [QW-1:0] quo_y;

  logic [FORCE_W-1:0] sat_x;
  logic [FORCE_W-1:0] sat_y;
  logic [CNT_OUT_W-1:0] cnt_sat;

  logic [FORCE_W-1:0] out_fx;
  logic [FORCE_W-1:0] out_fy;
  logic [CNT_OUT_W-1:0] out_cnt;

  assign in_pos_x = s_axis_tdata[9:0];
  assign in_pos_y = s_axis_tdata[19:10];
  assign in_pixel = s_axis_tdata[27:20];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {1'b0, out_cnt, out_fy, out_fx};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 10'd512;
      image_height <= 10'd512;
      inverse_divisor <= 16'd655;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     image_width <= cfg_data[9:0];
        CFG_IMAGE_HEIGHT:    image_height <= cfg_data[9:0];
        CFG_INVERSE_DIVISOR: inverse_divisor <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Current neighbor position and its bounds check.
  always_comb begin
    nx = $signed({2'b00, qx}) + {{(12 - OFF_W){oi[OFF_W-1]}}, oi};
    ny = $signed({2'b00, qy}) + {{(12 - OFF_W){oj[OFF_W-1]}}, oj};
    width_eff = (13'(image_width) > MAXW13) ? MAXW13 : 13'(image_width);
    height_eff = (13'(image_height) > MAXH13) ? MAXH13 : 13'(image_height);
    inb = !nx[11] && ({2'b00, nx[10:0]} < width_eff)
       && !ny[11] && ({2'b00, ny[10:0]} < height_eff);
    center = (oi == '0) && (oj == '0);
    tap.hit = (state == ST_SCAN) && inb && !center;
    tap.wx = weight_of(oi, oj);
    tap.wy = weight_of(oj, oi);
    rd_addr = ADDR_W'(32'(ny[10:0]) * MAX_WIDTH) + ADDR_W'(nx[10:0]);
  end

  // Pixel writes happen as the write word is taken, if its position lies inside the store.
  assign ram_we = accept && (s_axis_tuser == REQ_WRITE)
               && (32'(in_pos_x) < 32'(MAX_WIDTH))
               && (32'(in_pos_y) < 32'(MAX_HEIGHT));
  assign wr_addr = ADDR_W'(32'(in_pos_y) * MAX_WIDTH) + ADDR_W'(in_pos_x);
  assign mac_clear = accept && (s_axis_tuser == REQ_QUERY);

  wbf_pixel_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (in_pixel),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wbf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk             (clk),
    .rst             (rst),
    .clear           (mac_clear),
    .inverse_divisor (inverse_divisor),
    .tap_in          (tap),
    .pixel           (rd_data),
    .busy            (mac_busy),
    .sum_x           (sum_x),
    .sum_y           (sum_y)
  );

  // Magnitudes with half a divisor added, so the floor division rounds
  // ties away from zero.
  always_comb begin
    rnd = ACC_W'(cnt) << 15;
    mag_x = sum_x[ACC_W-1] ? (rnd - ACC_W'(sum_x)) : (ACC_W'(sum_x) + rnd);
    mag_y = sum_y[ACC_W-1] ? (rnd - ACC_W'(sum_y)) : (ACC_W'(sum_y) + rnd);
    div_start = (state == ST_PREP) && (cnt != '0);
  end

  wbf_divider #(
    .NUM_W (QW),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (mag_x[ACC_W-1:16]),
    .num_b (mag_y[ACC_W-1:16]),
    .den   (cnt),
    .done  (div_done),
    .quo_a (quo_x),
    .quo_b (quo_y)
  );

  // Sign and saturation of the quotients, count clipped to the field.
  always_comb begin
    if (neg_x) begin
      sat_x = (quo_x > QW'(24'h800000)) ? 24'h800000 : FORCE_W'(-quo_x);
    end else begin
      sat_x = (quo_x > QW'(24'h7FFFFF)) ? 24'h7FFFFF : FORCE_W'(quo_x);
    end
    if (neg_y) begin
      sat_y = (quo_y > QW'(24'h800000)) ? 24'h800000 : FORCE_W'(-quo_y);
    end else begin
      sat_y = (quo_y > QW'(24'h7FFFFF)) ? 24'h7FFFFF : FORCE_W'(quo_y);
    end
    cnt_sat = (32'(cnt) > 32'd127) ? 7'd127 : CNT_OUT_W'(cnt);
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      cnt <= '0;
      zero_res <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            oi <= OFF_LO;
            oj <= OFF_LO;
            qx <= in_pos_x;
            qy <= in_pos_y;
            if (s_axis_tuser == REQ_QUERY) begin
              zero_res <= 1'b0;
              state <= ST_SCAN;
            end else begin
              zero_res <= 1'b1;
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (tap.hit) begin
            cnt <= cnt + 1'b1;
          end
          if (oj == OFF_HI) begin
            oj <= OFF_LO;
            if (oi == OFF_HI) begin
              state <= ST_DRAIN;
            end else begin
              oi <= oi + 1'b1;
            end
          end else begin
            oj <= oj + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg_x <= sum_x[ACC_W-1];
          neg_y <= sum_y[ACC_W-1];
          if (cnt == '0) begin
            zero_res <= 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_fx <= zero_res ? '0 : sat_x;
            out_fy <= zero_res ? '0 : sat_y;
            out_cnt <= cnt_sat;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The pipeline only carries neighbors while a query scans or drains.
  assert property (@(posedge clk) disable iff (rst)
    mac_busy |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("mac pipeline busy outside of a scan");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside of the divide state");

  // The store is written only while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("pixel write while a query runs");

  // A word with no neighbors carries no force.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[54:48] == 7'd0))
      |-> (m_axis_tdata[47:0] == 48'd0))
    else $error("force without neighbors");
`endif

endmodule

`default_nettype wire
